FILE: hdl/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types and constants of the linked subset store.
// ----------------------------------------------------------------------------
package lss_pkg;

    localparam int SET_SIZE_DEF = 256;
    localparam int POS_W        = 8;
    localparam int REQ_W        = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_QUERY  = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } t_state;

endpackage

FILE: hdl/lss_ram.sv
// ----------------------------------------------------------------------------
// lss_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lss_ram
    import lss_pkg::*;
#(
    parameter int WIDTH = $clog2(SET_SIZE_DEF + 2),
    parameter int DEPTH = SET_SIZE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/linked_subset_store_top.sv
// ----------------------------------------------------------------------------
// linked_subset_store_top
// Subset of 0..SET_SIZE-1 kept as a doubly linked list in next/prev link
// RAMs with head and tail sentinels; query, insert, remove and clear.
//
//  channel  | dir | tdata                                       | tuser
//  ---------+-----+---------------------------------------------+---------
//  s_axis   | in  | position                                    | req_type
//  m_axis   | out | was_member, first_position, element_count,  | -
//           |     | set_empty                                   |
//
// a beat goes through accept with the link read, update and response; response waits for a free output
// the registered read of the link RAMs sets the update slot
// reset clears membership, head and count at once; no clearing pass
// a result waits in the output register; the next beat is taken meanwhile
// ----------------------------------------------------------------------------
module linked_subset_store_top
    import lss_pkg::*;
#(
    parameter int SET_SIZE = SET_SIZE_DEF,
    localparam int IW      = $clog2(SET_SIZE + 2),
    localparam int CW      = $clog2(SET_SIZE + 1),
    localparam int OBITS   = 1 + IW + CW + 1,
    localparam int OW      = ((OBITS + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [POS_W-1:0] i_s_axis_tdata,  // position
    input  logic [REQ_W-1:0] i_s_axis_tuser,  // req_type
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OW-1:0]    o_m_axis_tdata   // was_member, first_position,
                                              // element_count, set_empty
);

    localparam int AW = $clog2(SET_SIZE);
    localparam logic [IW-1:0] HEAD_L = IW'(SET_SIZE);
    localparam logic [IW-1:0] TAIL_L = IW'(SET_SIZE + 1);

    t_state               r_state, n_state;
    t_req                 r_req, n_req;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic                 r_ok, n_ok;
    logic                 r_was, n_was;
    logic [IW-1:0]        r_head, n_head;
    logic [CW-1:0]        r_count, n_count;
    logic [SET_SIZE-1:0]  r_flags, n_flags;
    logic [IW-1:0]        r_after, n_after;
    logic                 r_fix, n_fix;
    logic                 r_out_valid, n_out_valid;
    logic [OW-1:0]        r_out_data, n_out_data;

    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_in_ok;
    logic [AW-1:0]        w_in_addr;
    logic [AW-1:0]        w_pos_a;
    logic [IW-1:0]        w_pos_l;
    logic [IW-1:0]        w_first;

    logic                 w_nx_we, w_pv_we, w_re;
    logic [AW-1:0]        w_nx_waddr, w_pv_waddr;
    logic [IW-1:0]        w_nx_wdata, w_pv_wdata;
    logic [IW-1:0]        w_nx_rdata, w_pv_rdata;

    assign w_accept   = i_s_axis_tvalid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_in_ok    = 32'(i_s_axis_tdata) < SET_SIZE;
    assign w_in_addr  = AW'(i_s_axis_tdata);
    assign w_pos_a    = AW'(r_pos);
    assign w_pos_l    = IW'(r_pos);
    assign w_first    = (r_count == '0) ? HEAD_L : r_head;

    lss_ram #(
        .WIDTH (IW),
        .DEPTH (SET_SIZE)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (w_nx_we),
        .i_waddr (w_nx_waddr),
        .i_wdata (w_nx_wdata),
        .i_re    (w_re),
        .i_raddr (w_in_addr),
        .o_rdata (w_nx_rdata)
    );

    lss_ram #(
        .WIDTH (IW),
        .DEPTH (SET_SIZE)
    ) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (w_pv_we),
        .i_waddr (w_pv_waddr),
        .i_wdata (w_pv_wdata),
        .i_re    (w_re),
        .i_raddr (w_in_addr),
        .o_rdata (w_pv_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_axis_tready = (r_state == ST_IDLE);
        n_req       = r_req;
        n_pos       = r_pos;
        n_ok        = r_ok;
        n_was       = r_was;
        n_head      = r_head;
        n_count     = r_count;
        n_flags     = r_flags;
        n_after     = r_after;
        n_fix       = r_fix;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        w_re        = 1'b0;
        w_nx_we     = 1'b0;
        w_nx_waddr  = w_pos_a;
        w_nx_wdata  = r_head;
        w_pv_we     = 1'b0;
        w_pv_waddr  = w_pos_a;
        w_pv_wdata  = HEAD_L;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_req = t_req'(i_s_axis_tuser);
                    n_pos = i_s_axis_tdata;
                    n_ok  = w_in_ok;
                    n_was = w_in_ok && r_flags[w_in_addr];
                    n_fix = 1'b0;
                    w_re  = 1'b1;
                end
            end
            ST_EXEC: begin
                case (r_req)
                    REQ_CLEAR: begin
                        n_flags = '0;
                        n_head  = TAIL_L;
                        n_count = '0;
                    end
                    REQ_INSERT: begin
                        if (r_ok && !r_was) begin
                            w_nx_we          = 1'b1;
                            w_pv_we          = 1'b1;
                            n_head           = w_pos_l;
                            n_flags[w_pos_a] = 1'b1;
                            n_count          = r_count + CW'(1);
                            n_after          = r_head;
                            n_fix            = (r_head != TAIL_L);
                        end
                    end
                    REQ_REMOVE: begin
                        if (r_ok && r_was) begin
                            // unlink: next[prev] = next, prev[next] = prev
                            if (w_pv_rdata == HEAD_L) begin
                                n_head = w_nx_rdata;
                            end else begin
                                w_nx_we    = 1'b1;
                                w_nx_waddr = AW'(w_pv_rdata);
                                w_nx_wdata = w_nx_rdata;
                            end
                            if (w_nx_rdata != TAIL_L) begin
                                w_pv_we    = 1'b1;
                                w_pv_waddr = AW'(w_nx_rdata);
                                w_pv_wdata = w_pv_rdata;
                            end
                            n_flags[w_pos_a] = 1'b0;
                            n_count          = r_count - CW'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_RESP: begin
                // back link of the old first element
                if (r_fix) begin
                    w_pv_we    = 1'b1;
                    w_pv_waddr = AW'(r_after);
                    w_pv_wdata = w_pos_l;
                end
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = OW'({(r_count == '0), r_count, w_first, r_was});
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= TAIL_L;
            r_count     <= '0;
            r_flags     <= '0;
            r_fix       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_flags     <= n_flags;
            r_fix       <= n_fix;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_pos      <= n_pos;
        r_ok       <= n_ok;
        r_was      <= n_was;
        r_after    <= n_after;
        r_out_data <= n_out_data;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

FILE: tb/linked_subset_store_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_subset_store_top_tb
// Drives query, insert, remove and clear beats into the linked subset store
// and checks every response beat against a linked-list model that is kept
// in step with the accepted requests. Covers the empty set, the full set,
// repeated inserts, removes of absent positions and clears, under random
// gaps and stalls on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
module linked_subset_store_top_tb;
    import lss_pkg::*;

    localparam int REPLY_W   = 24;
    localparam int HEAD_SLOT = SET_SIZE_DEF;
    localparam int TAIL_SLOT = SET_SIZE_DEF + 1;

    typedef struct {
        logic       was_member;
        logic [8:0] first_position;
        logic [8:0] element_count;
        logic       set_empty;
    } t_set_reply;

    class subset_tracker;
        logic [8:0] nxt_link [0:SET_SIZE_DEF+1];
        logic [8:0] prv_link [0:SET_SIZE_DEF+1];
        bit         member   [0:SET_SIZE_DEF-1];
        logic [8:0] head;
        int         n_members;
        int         errors;
        t_set_reply replies [$];

        function new();
            for (int i = 0; i < SET_SIZE_DEF + 2; i++) begin
                nxt_link[i] = '0;
                prv_link[i] = '0;
            end
            foreach (member[i]) member[i] = 1'b0;
            head               = 9'(TAIL_SLOT);
            prv_link[TAIL_SLOT] = 9'(HEAD_SLOT);
            n_members          = 0;
            errors             = 0;
        endfunction

        function void log_request(t_req req, logic [7:0] pos);
            t_set_reply r;
            logic [8:0] nx;
            logic [8:0] pv;
            r.was_member = member[pos];
            case (req)
                REQ_CLEAR: begin
                    foreach (member[i]) member[i] = 1'b0;
                    head                = 9'(TAIL_SLOT);
                    prv_link[TAIL_SLOT] = 9'(HEAD_SLOT);
                    n_members           = 0;
                end
                REQ_INSERT: if (!r.was_member) begin
                    nxt_link[pos]  = head;
                    prv_link[head] = {1'b0, pos};
                    prv_link[pos]  = 9'(HEAD_SLOT);
                    head           = {1'b0, pos};
                    member[pos]    = 1'b1;
                    n_members++;
                end
                REQ_REMOVE: if (r.was_member) begin
                    nx = nxt_link[pos];
                    pv = prv_link[pos];
                    if (pv == 9'(HEAD_SLOT)) head = nx;
                    else nxt_link[pv] = nx;
                    prv_link[nx] = pv;
                    member[pos]  = 1'b0;
                    n_members--;
                end
                default: ;
            endcase
            r.first_position = (n_members == 0) ? 9'(SET_SIZE_DEF) : head;
            r.element_count  = 9'(n_members);
            r.set_empty      = (n_members == 0);
            replies.push_back(r);
        endfunction

        function void compare_field(string name, logic [8:0] want, logic [8:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_response(logic [REPLY_W-1:0] beat);
            t_set_reply want;
            if (replies.size() == 0) begin
                errors++;
                $display("%0t: response beat with no request pending, expected none, got %h",
                         $time, beat);
                return;
            end
            want = replies.pop_front();
            compare_field("was_member", 9'(want.was_member), 9'(beat[0]));
            compare_field("first_position", want.first_position, beat[9:1]);
            compare_field("element_count", want.element_count, beat[18:10]);
            compare_field("set_empty", 9'(want.set_empty), 9'(beat[19]));
        endfunction

        function int pending();
            return replies.size();
        endfunction

        // walks the list to a random member
        function logic [7:0] pick_member();
            logic [8:0] idx;
            int         steps;
            idx   = head;
            steps = $urandom_range(0, n_members - 1);
            repeat (steps) idx = nxt_link[idx];
            return idx[7:0];
        endfunction
    endclass

    logic                 clk     = 1'b0;
    logic                 rst_n   = 1'b0;
    logic                 s_valid = 1'b0;
    logic [POS_W-1:0]     s_data  = '0;
    logic [REQ_W-1:0]     s_user  = '0;
    logic                 m_ready = 1'b0;
    logic                 s_ready;
    logic                 m_valid;
    logic [REPLY_W-1:0]   m_data;

    subset_tracker sb = new();

    bit quiet      = 1'b0;
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    bit hold_req   = 1'b0;
    int sent       = 0;

    linked_subset_store_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // position
        .i_s_axis_tuser  (s_user),   // req_type
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)    // was_member, first_position, element_count, set_empty
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("linked_subset_store_top_tb NOT OK");
        $finish;
    end

    // response side: random stalls plus one long counted hold-off
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = 300;
            end else if (stall_left == 0 && !quiet && rx_idle_en && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 17);
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready) sb.check_response(m_data);
    end

    task automatic send_req(t_req req, logic [7:0] pos);
        @(negedge clk);
        s_valid <= 1'b1;
        s_data  <= pos;
        s_user  <= req;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        sb.log_request(req, pos);
        sent++;
    endtask

    task automatic sender_gap(int n);
        @(negedge clk);
        s_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic maybe_gap();
        if (!quiet && tx_idle_en && $urandom_range(0, 5) == 0) sender_gap($urandom_range(1, 17));
    endtask

    task automatic drain();
        sender_gap(1);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic send_random(int win);
        int         pick;
        int         base;
        t_req       req;
        logic [7:0] pos;
        base = $urandom_range(0, 255) & ~(win - 1);
        pos  = 8'(base + $urandom_range(0, win - 1));
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            req = REQ_INSERT;
        end else if (pick < 75) begin
            req = REQ_REMOVE;
            if (sb.n_members > 0 && $urandom_range(0, 4) != 0) pos = sb.pick_member();
        end else if (pick < 97) begin
            req = REQ_QUERY;
        end else begin
            req = REQ_CLEAR;
        end
        maybe_gap();
        send_req(req, pos);
    endtask

    task automatic fill_and_empty();
        logic [7:0] order [0:255];
        logic [7:0] tmp;
        int         j;
        for (int i = 0; i < 256; i++) order[i] = 8'(i);
        for (int i = 255; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        // long output hold-off while inserts keep coming
        tx_idle_en = 1'b0;
        hold_req   = 1'b1;
        for (int i = 0; i < 256; i++) begin
            if (i == 60) tx_idle_en = 1'b1;
            maybe_gap();
            send_req(REQ_INSERT, order[i]);
        end
        send_req(REQ_INSERT, order[17]);
        send_req(REQ_QUERY, 8'd255);
        drain();
        for (int i = 0; i < 256; i++) begin
            maybe_gap();
            send_req(REQ_REMOVE, order[(i * 7 + 3) % 256]);
        end
        send_req(REQ_QUERY, 8'd0);
    endtask

    initial begin
        int win;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_req(REQ_QUERY, 8'd0);
        send_req(REQ_REMOVE, 8'd5);
        send_req(REQ_INSERT, 8'd0);
        send_req(REQ_INSERT, 8'd255);
        send_req(REQ_INSERT, 8'd0);
        send_req(REQ_QUERY, 8'd255);
        send_req(REQ_QUERY, 8'd128);
        send_req(REQ_REMOVE, 8'd128);
        send_req(REQ_INSERT, 8'd128);
        send_req(REQ_REMOVE, 8'd255);
        send_req(REQ_REMOVE, 8'd128);
        send_req(REQ_REMOVE, 8'd0);
        send_req(REQ_INSERT, 8'd7);
        send_req(REQ_CLEAR, 8'd7);
        send_req(REQ_CLEAR, 8'd255);
        send_req(REQ_INSERT, 8'd255);
        send_req(REQ_INSERT, 8'd0);
        send_req(REQ_CLEAR, 8'd3);
        send_req(REQ_REMOVE, 8'd0);
        send_req(REQ_QUERY, 8'd255);
        send_req(REQ_INSERT, 8'd170);
        send_req(REQ_INSERT, 8'd85);
        send_req(REQ_REMOVE, 8'd170);
        send_req(REQ_REMOVE, 8'd85);

        fill_and_empty();

        while (sent < 1400) begin
            case ($urandom_range(0, 2))
                0:       win = 4;
                1:       win = 16;
                default: win = 256;
            endcase
            tx_idle_en = $urandom_range(0, 3) != 0;
            rx_idle_en = $urandom_range(0, 3) != 0;
            repeat (50) send_random(win);
        end

        quiet = 1'b1;
        repeat (200) send_random(16);

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("linked_subset_store_top_tb OK");
        end else begin
            $display("linked_subset_store_top_tb NOT OK");
        end
        $finish;
    end

endmodule
